/* rtl/cmdsp_pkg.sv */
// ----------------------------------------------------------------------------
// cmdsp_pkg
// Shared types, codes and microcode table of the argument splitter.
// ----------------------------------------------------------------------------
package cmdsp_pkg;

	// Default saturation point of the held backslash count
	localparam int MaxPendingBackslashes = 31;

	// Result kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// Input op codes
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOL  = 1'b1;

	// Special characters
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	// Sequencer step addresses
	typedef logic [3:0] step_t;
	localparam step_t STEP_FETCH   = 4'd0;
	localparam step_t STEP_EOL_BS  = 4'd1;
	localparam step_t STEP_EOL_END = 4'd2;
	localparam step_t STEP_DONE    = 4'd3;
	localparam step_t STEP_QE_BS   = 4'd4;
	localparam step_t STEP_QO_BS   = 4'd5;
	localparam step_t STEP_QO_Q    = 4'd6;
	localparam step_t STEP_W_BS    = 4'd7;
	localparam step_t STEP_W_END   = 4'd8;
	localparam step_t STEP_C_BS    = 4'd9;
	localparam step_t STEP_C_CHAR  = 4'd10;

	// Emit selector of a control word
	typedef logic [2:0] emit_t;
	localparam emit_t EMIT_NONE  = 3'd0;
	localparam emit_t EMIT_BS    = 3'd1;
	localparam emit_t EMIT_QUOTE = 3'd2;
	localparam emit_t EMIT_CHAR  = 3'd3;
	localparam emit_t EMIT_END   = 3'd4;
	localparam emit_t EMIT_DONE  = 3'd5;

	// Dispatch class of an accepted request
	typedef logic [2:0] cls_t;
	localparam cls_t CLS_SILENT    = 3'd0;
	localparam cls_t CLS_EOL_EMPTY = 3'd1;
	localparam cls_t CLS_EOL       = 3'd2;
	localparam cls_t CLS_QEVEN     = 3'd3;
	localparam cls_t CLS_QODD      = 3'd4;
	localparam cls_t CLS_WHITE     = 3'd5;
	localparam cls_t CLS_CHAR      = 3'd6;

	// One control word
	typedef struct packed {
		logic  dispatch;   // fetch step: take a request and branch on its class
		emit_t emit;       // result to produce
		logic  loop;       // repeat while the release counter is nonzero
		logic  cond;       // emit only if the token is open or quoted
		logic  last;       // result ends the run (loop: on its final pass)
		logic  close;      // token becomes empty
		logic  clear;      // all line state back to zero
		logic  jump_fetch; // next step is fetch instead of step + 1
	} ctrl_t;

	// Datapath status toward the sequencer
	typedef struct packed {
		logic in_fire;
		cls_t cls;
		logic emit_fire;
		logic skip;
		logic cnt_one;
	} stat_t;

	// Microcode table
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		w = '0;
		case (s)
			STEP_FETCH: begin
				w.dispatch = 1'b1;
			end
			STEP_EOL_BS: begin
				w.emit = EMIT_BS;
				w.loop = 1'b1;
			end
			STEP_EOL_END: begin
				w.emit = EMIT_END;
				w.cond = 1'b1;
			end
			STEP_DONE: begin
				w.emit       = EMIT_DONE;
				w.last       = 1'b1;
				w.clear      = 1'b1;
				w.jump_fetch = 1'b1;
			end
			STEP_QE_BS: begin
				w.emit       = EMIT_BS;
				w.loop       = 1'b1;
				w.last       = 1'b1;
				w.jump_fetch = 1'b1;
			end
			STEP_QO_BS: begin
				w.emit = EMIT_BS;
				w.loop = 1'b1;
			end
			STEP_QO_Q: begin
				w.emit       = EMIT_QUOTE;
				w.last       = 1'b1;
				w.jump_fetch = 1'b1;
			end
			STEP_W_BS: begin
				w.emit = EMIT_BS;
				w.loop = 1'b1;
			end
			STEP_W_END: begin
				w.emit       = EMIT_END;
				w.last       = 1'b1;
				w.close      = 1'b1;
				w.jump_fetch = 1'b1;
			end
			STEP_C_BS: begin
				w.emit = EMIT_BS;
				w.loop = 1'b1;
			end
			STEP_C_CHAR: begin
				w.emit       = EMIT_CHAR;
				w.last       = 1'b1;
				w.jump_fetch = 1'b1;
			end
			default: begin
				w.dispatch = 1'b1;
			end
		endcase
		return w;
	endfunction

	// Entry point of the routine for a request class
	function automatic step_t entry(cls_t c);
		step_t s;
		case (c)
			CLS_EOL_EMPTY: s = STEP_DONE;
			CLS_EOL:       s = STEP_EOL_BS;
			CLS_QEVEN:     s = STEP_QE_BS;
			CLS_QODD:      s = STEP_QO_BS;
			CLS_WHITE:     s = STEP_W_BS;
			CLS_CHAR:      s = STEP_C_BS;
			default:       s = STEP_FETCH;
		endcase
		return s;
	endfunction

endpackage

/* rtl/cmdsp_sequencer.sv */
// ----------------------------------------------------------------------------
// cmdsp_sequencer
// Step counter over the microcode table with dispatch and loop branches.
// ----------------------------------------------------------------------------
module cmdsp_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  cmdsp_pkg::stat_t stat,
	output cmdsp_pkg::ctrl_t ctrl
);

	cmdsp_pkg::step_t step_q;
	logic             advance;

	assign ctrl = cmdsp_pkg::ucode(step_q);

	// Step done: skipped, or emitted and not looping again
	assign advance = stat.skip || (stat.emit_fire && (!ctrl.loop || stat.cnt_one));

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cmdsp_pkg::STEP_FETCH;
		end else if (ctrl.dispatch) begin
			if (stat.in_fire) begin
				step_q <= cmdsp_pkg::entry(stat.cls);
			end
		end else if (advance) begin
			if (ctrl.jump_fetch) begin
				step_q <= cmdsp_pkg::STEP_FETCH;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/cmdsp_datapath.sv */
// ----------------------------------------------------------------------------
// cmdsp_datapath
// Line state, backslash counters, request decode and result register.
// ----------------------------------------------------------------------------
module cmdsp_datapath #(
	parameter int MAX_PENDING_BACKSLASHES = cmdsp_pkg::MaxPendingBackslashes
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmdsp_pkg::ctrl_t ctrl,
	output cmdsp_pkg::stat_t stat,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic [0:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	localparam int PW = $clog2(MAX_PENDING_BACKSLASHES + 1);

	logic          past_q;
	logic          inq_q;
	logic          token_q;
	logic          gap_q;
	logic [PW-1:0] pend_q;
	logic [PW-1:0] cnt_q;
	logic [7:0]    ch_q;

	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [7:0]    out_char_q;
	logic          out_last_q;

	logic            white;
	logic            in_fire;
	logic            can_emit;
	logic            cnt_zero;
	logic            skip;
	logic            emit_fire;
	logic            emit_last;
	logic [1:0]      emit_kind;
	logic [7:0]      emit_char;
	cmdsp_pkg::cls_t cls;

	assign s_tready = ctrl.dispatch;
	assign in_fire  = s_tvalid && ctrl.dispatch;
	assign white    = (s_tdata inside {[8'd9:8'd13], 8'd32});
	assign cnt_zero = (cnt_q == '0);

	// Request decode
	always_comb begin
		if (s_tuser[0] == cmdsp_pkg::OP_EOL) begin
			cls = past_q ? cmdsp_pkg::CLS_EOL : cmdsp_pkg::CLS_EOL_EMPTY;
		end else if (white && (!past_q || gap_q)) begin
			cls = cmdsp_pkg::CLS_SILENT;
		end else if (s_tdata == cmdsp_pkg::CH_QUOTE) begin
			cls = pend_q[0] ? cmdsp_pkg::CLS_QODD : cmdsp_pkg::CLS_QEVEN;
		end else if (s_tdata == cmdsp_pkg::CH_BACKSLASH) begin
			cls = cmdsp_pkg::CLS_SILENT;
		end else if (white && !inq_q) begin
			cls = cmdsp_pkg::CLS_WHITE;
		end else begin
			cls = cmdsp_pkg::CLS_CHAR;
		end
	end

	// Emit control
	assign can_emit  = !out_valid_q || m_tready;
	assign skip      = (ctrl.loop && cnt_zero) || (ctrl.cond && !(token_q || inq_q));
	assign emit_fire = (ctrl.emit != cmdsp_pkg::EMIT_NONE) && !skip && can_emit;
	assign emit_last = ctrl.last && (!ctrl.loop || (cnt_q == PW'(1)));

	always_comb begin
		case (ctrl.emit)
			cmdsp_pkg::EMIT_BS: begin
				emit_kind = cmdsp_pkg::KIND_CHAR;
				emit_char = cmdsp_pkg::CH_BACKSLASH;
			end
			cmdsp_pkg::EMIT_QUOTE: begin
				emit_kind = cmdsp_pkg::KIND_CHAR;
				emit_char = cmdsp_pkg::CH_QUOTE;
			end
			cmdsp_pkg::EMIT_CHAR: begin
				emit_kind = cmdsp_pkg::KIND_CHAR;
				emit_char = ch_q;
			end
			cmdsp_pkg::EMIT_END: begin
				emit_kind = cmdsp_pkg::KIND_END;
				emit_char = 8'd0;
			end
			cmdsp_pkg::EMIT_DONE: begin
				emit_kind = cmdsp_pkg::KIND_DONE;
				emit_char = 8'd0;
			end
			default: begin
				emit_kind = cmdsp_pkg::KIND_CHAR;
				emit_char = 8'd0;
			end
		endcase
	end

	assign stat.in_fire   = in_fire;
	assign stat.cls       = cls;
	assign stat.emit_fire = emit_fire;
	assign stat.skip      = skip;
	assign stat.cnt_one   = (cnt_q == PW'(1));

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			past_q  <= 1'b0;
			inq_q   <= 1'b0;
			token_q <= 1'b0;
			gap_q   <= 1'b0;
			pend_q  <= '0;
		end else if (ctrl.clear) begin
			if (emit_fire) begin
				past_q  <= 1'b0;
				inq_q   <= 1'b0;
				token_q <= 1'b0;
				gap_q   <= 1'b0;
				pend_q  <= '0;
			end
		end else if (in_fire) begin
			if (cls != cmdsp_pkg::CLS_EOL && cls != cmdsp_pkg::CLS_EOL_EMPTY &&
			    !(cls == cmdsp_pkg::CLS_SILENT && white)) begin
				past_q <= 1'b1;
				gap_q  <= (cls == cmdsp_pkg::CLS_WHITE);
			end
			if (cls == cmdsp_pkg::CLS_QEVEN) begin
				inq_q <= !inq_q;
			end
			if (cls == cmdsp_pkg::CLS_SILENT) begin
				// backslash counts up and saturates; skipped whitespace leaves it
				if (!white && pend_q < PW'(MAX_PENDING_BACKSLASHES)) begin
					pend_q <= pend_q + 1'b1;
				end
			end else begin
				pend_q <= '0;
			end
		end else if (emit_fire) begin
			if (ctrl.close) begin
				token_q <= 1'b0;
			end else if (emit_kind == cmdsp_pkg::KIND_CHAR) begin
				token_q <= 1'b1;
			end
		end
	end

	// Release counter and latched character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_fire) begin
			if (cls == cmdsp_pkg::CLS_QEVEN || cls == cmdsp_pkg::CLS_QODD) begin
				cnt_q <= pend_q >> 1;
			end else begin
				cnt_q <= pend_q;
			end
		end else if (emit_fire && ctrl.loop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q <= s_tdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_kind_q <= emit_kind;
			out_char_q <= emit_char;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

/* rtl/command_line_argument_splitter_unit.sv */
// ----------------------------------------------------------------------------
// command_line_argument_splitter_unit
// Splits a command line stream into argument characters and end marks.
// ----------------------------------------------------------------------------
// One character request at a time is run by a microcoded sequencer. Skipped
// whitespace and backslashes are taken at fetch alone. A character, whitespace
// that closes an argument, or a quote is taken at fetch, then runs the
// backslash release loop and an emit step for a closing result where there is
// one. End of line runs the release loop, an end step and a done step, or only
// the done step on an empty line. Each result comes from the release loop or an
// emit step and waits while m_tready holds the result register full.
module command_line_argument_splitter_unit #(
	parameter int MAX_PENDING_BACKSLASHES = cmdsp_pkg::MaxPendingBackslashes
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic [0:0] s_tuser,   // [0] op
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast    // last_of_run
);

	cmdsp_pkg::ctrl_t ctrl;
	cmdsp_pkg::stat_t stat;

	// Control program
	cmdsp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Datapath
	cmdsp_datapath #(
		.MAX_PENDING_BACKSLASHES(MAX_PENDING_BACKSLASHES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* rtl/cmdsp_checker.sv */
// ----------------------------------------------------------------------------
// cmdsp_checker
// Port-level checks of the argument splitter, bound to the top level.
// ----------------------------------------------------------------------------
module cmdsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic [0:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("result changed while stalled");

	// End and done marks carry no character
	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != cmdsp_pkg::KIND_CHAR |-> m_tdata == 8'd0)
		else $error("mark with nonzero character");

	// Done mark always ends its run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cmdsp_pkg::KIND_DONE |-> m_tlast)
		else $error("done mark not last of run");

	// Only defined kinds appear
	a_kind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == cmdsp_pkg::KIND_CHAR || m_tuser == cmdsp_pkg::KIND_END ||
		m_tuser == cmdsp_pkg::KIND_DONE)
		else $error("undefined result kind");

	// A backslash is only counted, so the next request is taken at once
	a_bs_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == cmdsp_pkg::OP_CHAR &&
		s_tdata == cmdsp_pkg::CH_BACKSLASH |=> s_tready)
		else $error("backslash request stalled the input");

endmodule

bind command_line_argument_splitter_unit cmdsp_checker u_cmdsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
